/* design/prefix_hash_interval_engine_defines.svh */
// Assertion macros for the top-level file, which checks its own logic.
`ifndef PREFIX_HASH_INTERVAL_ENGINE_DEFINES_SVH
`define PREFIX_HASH_INTERVAL_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* design/phie_pkg.sv */
`default_nettype none

package phie_pkg;

  localparam int HASH_W   = 64;
  localparam int HALF_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 12;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic [HASH_W-1:0] BASE_RESET = 64'd100000000003;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               order_bad;
    logic [HASH_W-1:0]  ext;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_APPEND,
    B_QREAD,
    B_QMUL_GO,
    B_QMUL,
    B_QOUT
  } back_state_t;

  typedef struct packed {
    logic idle;
    logic out_load;
  } back_status_t;

  // Addition modulo 2^64-1: the carry out wraps around into bit 0.
  function automatic logic [HASH_W-1:0] eac_add(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[HASH_W-1:0] + {{(HASH_W-1){1'b0}}, s[HASH_W]};
  endfunction

endpackage

`default_nettype wire

/* design/phie_front.sv */
`default_nettype none

module phie_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [phie_pkg::FUNC_W-1:0]     func,
  input  wire logic [phie_pkg::BYTE_W-1:0]     char_byte,
  input  wire logic [phie_pkg::FIELD_W-1:0]    lo,
  input  wire logic [phie_pkg::FIELD_W-1:0]    hi,
  output logic                                 push_valid,
  output phie_pkg::cmd_t                       push_cmd,
  input  wire logic                            push_ready
);

  logic           accept;
  phie_pkg::cmd_t cmd_next;

  assign in_stall = push_valid && !push_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd_next.ext = {{(phie_pkg::HASH_W - phie_pkg::BYTE_W){char_byte[phie_pkg::BYTE_W-1]}},
                    char_byte};
    cmd_next.lo        = lo;
    cmd_next.hi        = hi;
    cmd_next.order_bad = lo > hi;
    case (func)
      phie_pkg::FUNC_APPEND: begin
        cmd_next.op = phie_pkg::OP_APPEND;
      end
      phie_pkg::FUNC_QUERY: begin
        cmd_next.op = phie_pkg::OP_QUERY;
      end
      phie_pkg::FUNC_CLEAR: begin
        cmd_next.op = phie_pkg::OP_CLEAR;
      end
      default: begin
        cmd_next.op = phie_pkg::OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (accept) begin
      push_valid <= 1'b1;
    end else if (push_ready) begin
      push_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

/* design/phie_queue.sv */
`default_nettype none

module phie_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire phie_pkg::cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output phie_pkg::cmd_t      pop_cmd,
  input  wire logic           pop
);

  localparam logic [phie_pkg::QPTR_W-1:0] PTR_LAST = phie_pkg::QPTR_W'(phie_pkg::QUEUE_DEPTH - 1);
  localparam logic [phie_pkg::QCNT_W-1:0] CNT_FULL = phie_pkg::QCNT_W'(phie_pkg::QUEUE_DEPTH);

  phie_pkg::cmd_t                entries [phie_pkg::QUEUE_DEPTH];
  logic [phie_pkg::QPTR_W-1:0]   wr_ptr;
  logic [phie_pkg::QPTR_W-1:0]   rd_ptr;
  logic [phie_pkg::QCNT_W-1:0]   count;
  logic                          push;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/phie_mul.sv */
`default_nettype none

// Product modulo 2^64-1 from four 32x32 partial products, one per cycle.
// Since 2^64 is 1 in this ring, a partial product at bit 32 is a 32-bit rotate
// and one at bit 64 needs no shift at all.
module phie_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [phie_pkg::HASH_W-1:0]  x,
  input  wire logic [phie_pkg::HASH_W-1:0]  y,
  output logic                              done,
  output logic [phie_pkg::HASH_W-1:0]       result
);

  logic [phie_pkg::HASH_W-1:0] xr;
  logic [phie_pkg::HASH_W-1:0] yr;
  logic [1:0]                  step;
  logic                        run;
  logic                        prod_vld;
  logic                        prod_last;
  logic                        prod_rot;
  logic [phie_pkg::HASH_W-1:0] prod;
  logic [phie_pkg::HASH_W-1:0] prod_in;
  logic [phie_pkg::HASH_W-1:0] acc;
  logic [phie_pkg::HALF_W-1:0] a_half;
  logic [phie_pkg::HALF_W-1:0] b_half;

  assign a_half  = step[1] ? xr[phie_pkg::HASH_W-1:phie_pkg::HALF_W] : xr[phie_pkg::HALF_W-1:0];
  assign b_half  = step[0] ? yr[phie_pkg::HASH_W-1:phie_pkg::HALF_W] : yr[phie_pkg::HALF_W-1:0];
  assign prod_in = prod_rot ? {prod[phie_pkg::HALF_W-1:0], prod[phie_pkg::HASH_W-1:phie_pkg::HALF_W]}
                            : prod;
  assign result  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      step     <= '0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= prod_vld && prod_last;
      prod_vld <= run;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == 2'd3) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= y;
      acc <= '0;
    end else if (prod_vld) begin
      acc <= phie_pkg::eac_add(acc, prod_in);
    end
    if (run) begin
      prod      <= {{phie_pkg::HALF_W{1'b0}}, a_half} * {{phie_pkg::HALF_W{1'b0}}, b_half};
      prod_last <= step == 2'd3;
      prod_rot  <= step[1] ^ step[0];
    end
  end

endmodule

`default_nettype wire

/* design/phie_back.sv */
`default_nettype none

module phie_back #(
  parameter int MAX_LEN = 4095
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [phie_pkg::HASH_W-1:0]     cfg_wr_data,
  input  wire logic                            q_valid,
  input  wire phie_pkg::cmd_t                  q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [phie_pkg::HASH_W-1:0]          hash_value,
  output logic [phie_pkg::STATUS_W-1:0]        status,
  output phie_pkg::back_status_t               stat
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (LEN_W > phie_pkg::FIELD_W) ? LEN_W : phie_pkg::FIELD_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  phie_pkg::back_state_t state;
  phie_pkg::back_state_t state_next;
  phie_pkg::cmd_t        cmd;

  logic [phie_pkg::HASH_W-1:0] base;
  logic [phie_pkg::HASH_W-1:0] h_last;
  logic [phie_pkg::HASH_W-1:0] p_last;
  logic [LEN_W-1:0]            length;

  logic [phie_pkg::HASH_W-1:0] prefix_mem [MAX_LEN + 1];
  logic [phie_pkg::HASH_W-1:0] power_mem  [MAX_LEN + 1];
  logic [phie_pkg::HASH_W-1:0] rd_h_lo;
  logic [phie_pkg::HASH_W-1:0] rd_h_hi;
  logic [phie_pkg::HASH_W-1:0] rd_pw;
  logic                        lo_zero;
  logic                        hi_zero;
  logic                        df_zero;
  logic [phie_pkg::HASH_W-1:0] h_lo;
  logic [phie_pkg::HASH_W-1:0] h_hi;
  logic [phie_pkg::HASH_W-1:0] pw;
  logic [phie_pkg::HASH_W-1:0] diff;

  logic                        out_free;
  logic                        take;
  logic                        full;
  logic                        q_bad;
  logic [IDX_W-1:0]            qhi_x;
  logic [IDX_W-1:0]            len_x;
  logic [IDX_W-1:0]            lo_x;
  logic [IDX_W-1:0]            hi_x;
  logic [IDX_W-1:0]            df_x;
  logic [LEN_W-1:0]            wr_a;
  logic [phie_pkg::HASH_W-1:0] h_new;

  logic                        mul_h_start;
  logic                        mul_p_start;
  logic                        mul_h_done;
  logic                        mul_p_done;
  logic [phie_pkg::HASH_W-1:0] mul_h_x;
  logic [phie_pkg::HASH_W-1:0] mul_h_y;
  logic [phie_pkg::HASH_W-1:0] mul_h_res;
  logic [phie_pkg::HASH_W-1:0] mul_p_res;

  logic                          out_load;
  logic [phie_pkg::STATUS_W-1:0] out_status;
  logic [phie_pkg::HASH_W-1:0]   out_hash;
  logic                          app_done;
  logic                          mem_rd;
  logic                          diff_load;
  logic                          do_clear;

  assign out_free = !out_valid || !out_stall;
  assign take     = (state == phie_pkg::B_IDLE) && q_valid && out_free;
  assign full     = length == LEN_MAX;
  assign qhi_x    = IDX_W'(q_cmd.hi);
  assign len_x    = IDX_W'(length);
  assign q_bad    = q_cmd.order_bad || (qhi_x > len_x);

  assign lo_x  = IDX_W'(cmd.lo);
  assign hi_x  = IDX_W'(cmd.hi);
  assign df_x  = hi_x - lo_x;
  assign wr_a  = length + LEN_W'(1);
  assign h_new = phie_pkg::eac_add(mul_h_res, cmd.ext);

  // Entry 0 of each table is never written: the empty prefix is read as a constant.
  assign h_lo = lo_zero ? '0 : rd_h_lo;
  assign h_hi = hi_zero ? '0 : rd_h_hi;
  assign pw   = df_zero ? phie_pkg::HASH_W'(1) : rd_pw;

  assign mul_h_x = (state == phie_pkg::B_QMUL_GO) ? h_lo : h_last;
  assign mul_h_y = (state == phie_pkg::B_QMUL_GO) ? pw   : base;

  assign stat.idle     = state == phie_pkg::B_IDLE;
  assign stat.out_load = out_load;

  phie_mul u_mul_h (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_h_start),
    .x      (mul_h_x),
    .y      (mul_h_y),
    .done   (mul_h_done),
    .result (mul_h_res)
  );

  phie_mul u_mul_p (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_p_start),
    .x      (p_last),
    .y      (base),
    .done   (mul_p_done),
    .result (mul_p_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      phie_pkg::B_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            phie_pkg::OP_APPEND: begin
              if (!full) begin
                state_next = phie_pkg::B_APPEND;
              end
            end
            phie_pkg::OP_QUERY: begin
              if (!q_bad) begin
                state_next = phie_pkg::B_QREAD;
              end
            end
            default: begin
              state_next = phie_pkg::B_IDLE;
            end
          endcase
        end
      end
      phie_pkg::B_APPEND: begin
        if (mul_h_done && mul_p_done) begin
          state_next = phie_pkg::B_IDLE;
        end
      end
      phie_pkg::B_QREAD: begin
        state_next = phie_pkg::B_QMUL_GO;
      end
      phie_pkg::B_QMUL_GO: begin
        state_next = phie_pkg::B_QMUL;
      end
      phie_pkg::B_QMUL: begin
        if (mul_h_done) begin
          state_next = phie_pkg::B_QOUT;
        end
      end
      phie_pkg::B_QOUT: begin
        state_next = phie_pkg::B_IDLE;
      end
      default: begin
        state_next = phie_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop       = take;
    mul_h_start = 1'b0;
    mul_p_start = 1'b0;
    out_load    = 1'b0;
    out_status  = phie_pkg::STATUS_OK;
    out_hash    = '0;
    app_done    = 1'b0;
    mem_rd      = 1'b0;
    diff_load   = 1'b0;
    do_clear    = 1'b0;
    case (state)
      phie_pkg::B_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            phie_pkg::OP_APPEND: begin
              if (full) begin
                out_load   = 1'b1;
                out_status = phie_pkg::STATUS_FULL;
              end else begin
                mul_h_start = 1'b1;
                mul_p_start = 1'b1;
              end
            end
            phie_pkg::OP_QUERY: begin
              if (q_bad) begin
                out_load   = 1'b1;
                out_status = phie_pkg::STATUS_BAD;
              end
            end
            phie_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              do_clear = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      phie_pkg::B_APPEND: begin
        if (mul_h_done && mul_p_done) begin
          app_done = 1'b1;
          out_load = 1'b1;
        end
      end
      phie_pkg::B_QREAD: begin
        mem_rd = 1'b1;
      end
      phie_pkg::B_QMUL_GO: begin
        mul_h_start = 1'b1;
      end
      phie_pkg::B_QMUL: begin
        diff_load = mul_h_done;
      end
      phie_pkg::B_QOUT: begin
        out_load = 1'b1;
        out_hash = (diff == '1) ? '0 : diff;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phie_pkg::B_IDLE;
      out_valid <= 1'b0;
      base      <= phie_pkg::BASE_RESET;
      length    <= '0;
      h_last    <= '0;
      p_last    <= phie_pkg::HASH_W'(1);
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && out_stall);
      if (cfg_wr_en) begin
        base <= cfg_wr_data;
      end
      if (do_clear) begin
        length <= '0;
        h_last <= '0;
        p_last <= phie_pkg::HASH_W'(1);
      end else if (app_done) begin
        length <= wr_a;
        h_last <= h_new;
        p_last <= mul_p_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= q_cmd;
    end
    if (out_load) begin
      hash_value <= out_hash;
      status     <= out_status;
    end
    if (diff_load) begin
      diff <= phie_pkg::eac_add(h_hi, ~mul_h_res);
    end
    if (mem_rd) begin
      lo_zero <= lo_x == '0;
      hi_zero <= hi_x == '0;
      df_zero <= df_x == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (app_done) begin
      prefix_mem[wr_a] <= h_new;
      power_mem[wr_a]  <= mul_p_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_h_lo <= prefix_mem[lo_x[LEN_W-1:0]];
      rd_h_hi <= prefix_mem[hi_x[LEN_W-1:0]];
      rd_pw   <= power_mem[df_x[LEN_W-1:0]];
    end
  end

endmodule

`default_nettype wire

/* design/prefix_hash_interval_engine.sv */
// Channel  Direction  Handshake               Fields
// in       input      in_valid / in_stall     func, char_byte, lo, hi
// out      output     out_valid / out_stall   hash_value, status
// cfg      input      cfg_wr_en               cfg_wr_data (base)
//
// Clear, no-op, full append and bad query: answered straight from the idle state.
// Append: two multiplies in parallel on 32x32 multipliers that take four partial products.
// Query: the table reads, then one pass through one of those multipliers.
// rst is synchronous; tables need no clearing pass, entry 0 is read as a constant.
// A two-beat queue lets the input keep taking beats while the back end is busy
// or the output is stalled.
`default_nettype none
`include "prefix_hash_interval_engine_defines.svh"

module prefix_hash_interval_engine #(
  parameter int MAX_LEN = 4095
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [phie_pkg::HASH_W-1:0]     cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [phie_pkg::FUNC_W-1:0]     func,
  input  wire logic [phie_pkg::BYTE_W-1:0]     char_byte,
  input  wire logic [phie_pkg::FIELD_W-1:0]    lo,
  input  wire logic [phie_pkg::FIELD_W-1:0]    hi,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [phie_pkg::HASH_W-1:0]          hash_value,
  output logic [phie_pkg::STATUS_W-1:0]        status
);

  logic                   push_valid;
  logic                   push_ready;
  phie_pkg::cmd_t         push_cmd;
  logic                   q_valid;
  logic                   q_pop;
  phie_pkg::cmd_t         q_cmd;
  phie_pkg::back_status_t stat;

  phie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .char_byte  (char_byte),
    .lo         (lo),
    .hi         (hi),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  phie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  phie_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value),
    .status      (status),
    .stat        (stat)
  );

  // The back end only takes a beat that the queue actually holds.
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, q_valid)
  // A new result never lands on one that is still waiting to be taken.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, stat.out_load, !(out_valid && out_stall))
  // Every loaded result shows up on the output in the following cycle.
  `ASSERT_NEXT(a_load_shows, clk, rst, stat.out_load, out_valid)

endmodule

`default_nettype wire
